@@ src/shs_pkg.sv @@
// Shared types and constants for the SHA-1 stream hash unit.
// No dependencies; imported by the top level, shs_front and shs_back.
package shs_pkg;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [3:0] LEN_HI_WORD = 4'd14;
   localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

   localparam logic [31:0] IV_WORDS [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_STAGE0 = 32'h5A827999;
   localparam logic [31:0] K_STAGE1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_STAGE2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_STAGE3 = 32'hCA62C1D6;

   // One message word on its way from the front end to the round engine.
   typedef struct packed {
      logic        final_block;
      logic [31:0] word;
   } entry_type;

   // One digest word on its way to the result queue.
   typedef struct packed {
      logic        last_word;
      logic [2:0]  word_index;
      logic [31:0] digest_word;
   } result_type;

   typedef enum logic [1:0] {
      FR_ACCEPT,
      FR_PAD,
      FR_LEN_LO
   } front_state_type;

   typedef enum logic [1:0] {
      BK_LOAD,
      BK_EXPAND,
      BK_ADD,
      BK_DIGEST
   } back_state_type;

endpackage

@@ src/sha1_stream_hash_unit.sv @@
// Top level of the SHA-1 stream hash unit: front end, word queue, round
// engine and result queue. Uses shs_pkg, shs_front, shs_fifo, shs_back.
//
//   Channel   Direction  Handshake          Payload
//   request   in         req_push/req_full  req_cmd, req_data_byte
//   response  out        rsp_pop/rsp_empty  rsp_digest_word, rsp_word_index,
//                                           rsp_last_word
//
// An absorb transaction carries one byte; every fourth byte puts a word in the
// word queue. The single round unit runs 16 rounds of a block as its words
// arrive, then the other 64 rounds and an add step, so the word queue lets the
// front end take the next block's bytes while a block is compressed.
// A finish transaction holds req_full high while the padding and length words
// are written; the digest follows after one or two compressions, as five words.
// Reset is synchronous and loads the initial vector. A stalled result queue
// stops the round engine at the digest read-out only; input is still taken
// until the word queue fills.
module sha1_stream_hash_unit
   import shs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 8,
   parameter int RESULT_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   entry_type  q_wr_entry, q_rd_entry;
   result_type out_wr_entry, out_rd_entry;
   logic       q_push, q_full, q_pop, q_empty;
   logic       out_push, out_full;

   shs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .q_push        (q_push),
      .q_entry       (q_wr_entry),
      .q_full        (q_full)
   );

   shs_fifo #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_word_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_entry),
      .empty     (q_empty)
   );

   shs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_entry   (q_rd_entry),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .out_push  (out_push),
      .out_entry (out_wr_entry),
      .out_full  (out_full)
   );

   shs_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_entry),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_rd_entry),
      .empty     (rsp_empty)
   );

   assign rsp_digest_word = out_rd_entry.digest_word;
   assign rsp_word_index  = out_rd_entry.word_index;
   assign rsp_last_word   = out_rd_entry.last_word;

endmodule

@@ src/shs_fifo.sv @@
// Small synchronous FIFO built from registers, used for the word queue
// and the result queue. No package dependencies.
module shs_fifo #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/shs_front.sv @@
// Front end: takes absorb and finish commands, packs bytes into big-endian
// words and generates the padding and length words. Uses shs_pkg.
module shs_front
   import shs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_push,
   output logic      req_full,
   input  logic      req_cmd,
   input  logic [7:0] req_data_byte,
   output logic      q_push,
   output entry_type q_entry,
   input  logic      q_full
);

   front_state_type state_ff, state_in;
   logic [60:0] byte_cnt_ff, byte_cnt_in;
   logic [23:0] pack_ff, pack_in;
   logic [3:0]  pad_idx_ff, pad_idx_in;
   logic        accept;
   logic [31:0] pad_word;

   assign req_full = (state_ff != FR_ACCEPT) || q_full;
   assign accept   = req_push && !req_full;

   // The word that holds the 0x80 marker, with the bytes already packed.
   always_comb begin
      case (byte_cnt_ff[1:0])
         2'd0:    pad_word = {PAD_BYTE, 24'h0};
         2'd1:    pad_word = {pack_ff[7:0], PAD_BYTE, 16'h0};
         2'd2:    pad_word = {pack_ff[15:0], PAD_BYTE, 8'h0};
         default: pad_word = {pack_ff, PAD_BYTE};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_ACCEPT: begin
            if (accept && req_cmd == CMD_FINISH) begin
               state_in = FR_PAD;
            end
         end
         FR_PAD: begin
            if (!q_full && pad_idx_ff == LEN_HI_WORD) begin
               state_in = FR_LEN_LO;
            end
         end
         FR_LEN_LO: begin
            if (!q_full) begin
               state_in = FR_ACCEPT;
            end
         end
         default: state_in = FR_ACCEPT;
      endcase
   end

   always_comb begin
      q_push              = 1'b0;
      q_entry.final_block = 1'b0;
      q_entry.word        = {pack_ff, req_data_byte};
      case (state_ff)
         FR_ACCEPT: begin
            if (accept && req_cmd == CMD_FINISH) begin
               q_push       = 1'b1;
               q_entry.word = pad_word;
            end else if (accept && byte_cnt_ff[1:0] == 2'd3) begin
               q_push = 1'b1;
            end
         end
         FR_PAD: begin
            q_push       = !q_full;
            // Bits 63:32 of the message bit count.
            q_entry.word = (pad_idx_ff == LEN_HI_WORD) ? byte_cnt_ff[60:29] : 32'h0;
         end
         FR_LEN_LO: begin
            q_push              = !q_full;
            q_entry.final_block = 1'b1;
            q_entry.word        = {byte_cnt_ff[28:0], 3'b000};
         end
         default: q_push = 1'b0;
      endcase
   end

   always_comb begin
      byte_cnt_in = byte_cnt_ff;
      pack_in     = pack_ff;
      pad_idx_in  = pad_idx_ff;
      if (state_ff == FR_ACCEPT && accept) begin
         if (req_cmd == CMD_ABSORB) begin
            byte_cnt_in = byte_cnt_ff + 61'd1;
            pack_in     = {pack_ff[15:0], req_data_byte};
         end else begin
            pad_idx_in = byte_cnt_ff[5:2] + 4'd1;
         end
      end
      if (state_ff == FR_PAD && !q_full) begin
         pad_idx_in = pad_idx_ff + 4'd1;
      end
      if (state_ff == FR_LEN_LO && !q_full) begin
         byte_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FR_ACCEPT;
         byte_cnt_ff <= '0;
         pad_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         byte_cnt_ff <= byte_cnt_in;
         pad_idx_ff  <= pad_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pack_ff <= pack_in;
   end

endmodule

@@ src/shs_back.sv @@
// Back end: one SHA-1 round per cycle, except that a load round waits for a queued word;
// a 16-word schedule shift line, the chaining words and the digest read-out. Uses shs_pkg.
module shs_back
   import shs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  q_entry,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       out_push,
   output result_type out_entry,
   input  logic       out_full
);

   localparam logic [6:0] LAST_LOAD_ROUND = 7'd15;
   localparam logic [6:0] LAST_ROUND      = 7'd79;

   back_state_type state_ff, state_in;
   logic [6:0]  round_ff, round_in;
   logic [31:0] regs_ff [5];
   logic [31:0] regs_in [5];
   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] w_ff [16];
   logic        final_ff, final_in;
   logic [2:0]  dig_idx_ff, dig_idx_in;
   logic        round_en;
   logic [31:0] w_exp, w_cur, f_val, k_val, tmp;
   logic [31:0] sum_words [5];

   // Schedule taps: w_ff[15] is the word of the previous round.
   assign w_exp = {w_ff[13][30:0] ^ w_ff[8][30:0] ^ w_ff[2][30:0] ^ w_ff[0][30:0],
                   w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};
   assign w_cur = (state_ff == BK_LOAD) ? q_entry.word : w_exp;
   assign round_en = (state_ff == BK_LOAD && !q_empty) || (state_ff == BK_EXPAND);

   always_comb begin
      if (round_ff inside {[7'd0:7'd19]}) begin
         f_val = (regs_ff[1] & regs_ff[2]) | (~regs_ff[1] & regs_ff[3]);
         k_val = K_STAGE0;
      end else if (round_ff inside {[7'd20:7'd39]}) begin
         f_val = regs_ff[1] ^ regs_ff[2] ^ regs_ff[3];
         k_val = K_STAGE1;
      end else if (round_ff inside {[7'd40:7'd59]}) begin
         f_val = (regs_ff[1] & regs_ff[2]) | (regs_ff[1] & regs_ff[3]) |
                 (regs_ff[2] & regs_ff[3]);
         k_val = K_STAGE2;
      end else begin
         f_val = regs_ff[1] ^ regs_ff[2] ^ regs_ff[3];
         k_val = K_STAGE3;
      end
   end

   assign tmp = {regs_ff[0][26:0], regs_ff[0][31:27]} + f_val + regs_ff[4] + k_val + w_cur;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         sum_words[i] = chain_ff[i] + regs_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_LOAD: begin
            if (!q_empty && round_ff == LAST_LOAD_ROUND) begin
               state_in = BK_EXPAND;
            end
         end
         BK_EXPAND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = BK_ADD;
            end
         end
         BK_ADD: state_in = final_ff ? BK_DIGEST : BK_LOAD;
         BK_DIGEST: begin
            if (!out_full && dig_idx_ff == LAST_WORD_INDEX) begin
               state_in = BK_LOAD;
            end
         end
         default: state_in = BK_LOAD;
      endcase
   end

   always_comb begin
      q_pop                 = 1'b0;
      out_push              = 1'b0;
      out_entry.digest_word = chain_ff[dig_idx_ff];
      out_entry.word_index  = dig_idx_ff;
      out_entry.last_word   = (dig_idx_ff == LAST_WORD_INDEX);
      case (state_ff)
         BK_LOAD:   q_pop = !q_empty;
         BK_DIGEST: out_push = !out_full;
         default:   q_pop = 1'b0;
      endcase
   end

   always_comb begin
      round_in   = round_ff;
      final_in   = final_ff;
      dig_idx_in = dig_idx_ff;
      regs_in    = regs_ff;
      chain_in   = chain_ff;
      if (round_en) begin
         round_in   = (round_ff == LAST_ROUND) ? 7'd0 : round_ff + 7'd1;
         regs_in[0] = tmp;
         regs_in[1] = regs_ff[0];
         regs_in[2] = {regs_ff[1][1:0], regs_ff[1][31:2]};
         regs_in[3] = regs_ff[2];
         regs_in[4] = regs_ff[3];
      end
      if (state_ff == BK_LOAD && !q_empty) begin
         final_in = q_entry.final_block;
      end
      // The sum also seeds the working registers for the next block.
      if (state_ff == BK_ADD) begin
         chain_in = sum_words;
         regs_in  = sum_words;
      end
      if (state_ff == BK_DIGEST && !out_full) begin
         if (dig_idx_ff == LAST_WORD_INDEX) begin
            dig_idx_in = 3'd0;
            final_in   = 1'b0;
            chain_in   = IV_WORDS;
            regs_in    = IV_WORDS;
         end else begin
            dig_idx_in = dig_idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_LOAD;
         round_ff   <= '0;
         final_ff   <= 1'b0;
         dig_idx_ff <= '0;
         regs_ff    <= IV_WORDS;
         chain_ff   <= IV_WORDS;
      end else begin
         state_ff   <= state_in;
         round_ff   <= round_in;
         final_ff   <= final_in;
         dig_idx_ff <= dig_idx_in;
         regs_ff    <= regs_in;
         chain_ff   <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_cur;
      end
   end

endmodule
